[rtl/core/svalloc_pkg.sv]
// shared types and constants of the voice slot allocator
`timescale 1ns / 1ps

package svalloc_pkg;

  localparam int NUM_SLOTS    = 9;
  localparam int SLOT_W       = 5;
  localparam int CHAN_W       = 4;
  localparam int NOTE_W       = 7;
  localparam int TIME_W       = 32;
  localparam int NUM_CHANNELS = 16;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [NOTE_W-1:0] THR_RESET  = 7'd64;
  localparam logic [CHAN_W-1:0] PERC_RESET = 4'd9;

  localparam logic REG_SUSTAIN    = 1'b0;
  localparam logic REG_PERCUSSION = 1'b1;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_PEDAL    = 2'd2,
    OP_TOUCH    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_KEYON   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_STEAL   = 2'd2,
    ACT_DROP    = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEAL,
    ST_EXTRA,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic              vld;
    op_e               op;
    logic              steal;
    logic [CHAN_W-1:0] ch;
    logic [NOTE_W-1:0] nt;
    logic [TIME_W-1:0] now;
    logic              hold;
    logic              rel;
    logic              claimed;
    logic              found;
    logic [TIME_W-1:0] best_time;
    logic [SLOT_W-1:0] best_idx;
  } tok_t;

  typedef struct packed {
    logic              vld;
    act_e              action;
    logic [SLOT_W-1:0] slot;
    logic [NOTE_W-1:0] note;
    logic [CHAN_W-1:0] chan;
  } res_t;

  typedef struct packed {
    logic              free;
    logic              held;
    logic [CHAN_W-1:0] owner;
    logic [NOTE_W-1:0] pitch;
    logic [TIME_W-1:0] stamp;
  } slot_t;

endpackage

[rtl/core/svalloc_cell.sv]
// one voice slot cell of the allocator chain
`timescale 1ns / 1ps

module svalloc_cell import svalloc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [SLOT_W-1:0] slot_idx_i,
  input  tok_t              tok_i,
  output tok_t              tok_o,
  output res_t              res_o
);

  tok_t  tok_q, tok_d;
  res_t  res_q, res_d;
  slot_t slot_q, slot_d;
  logic  match;

  assign match = !slot_q.free && (slot_q.owner == tok_i.ch);

  always_comb begin
    tok_d  = tok_i;
    res_d  = '0;
    slot_d = slot_q;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_NOTE_ON: begin
          if (tok_i.steal) begin
            if (slot_idx_i == tok_i.best_idx) begin
              res_d = '{vld: 1'b1, action: ACT_STEAL, slot: slot_idx_i,
                        note: slot_q.pitch, chan: slot_q.owner};
              slot_d = '{free: 1'b0, held: 1'b0, owner: tok_i.ch,
                         pitch: tok_i.nt, stamp: tok_i.now};
            end
          end else begin
            if (slot_q.free && !tok_i.claimed) begin
              res_d = '{vld: 1'b1, action: ACT_KEYON, slot: slot_idx_i,
                        note: tok_i.nt, chan: tok_i.ch};
              slot_d = '{free: 1'b0, held: 1'b0, owner: tok_i.ch,
                         pitch: tok_i.nt, stamp: tok_i.now};
              tok_d.claimed = 1'b1;
            end
            if (!slot_q.free && (slot_q.stamp < tok_i.best_time)) begin
              tok_d.best_time = slot_q.stamp;
              tok_d.best_idx  = slot_idx_i;
              tok_d.found     = 1'b1;
            end
          end
        end
        OP_NOTE_OFF: begin
          if (match && (slot_q.pitch == tok_i.nt)) begin
            if (tok_i.hold) begin
              slot_d.held = 1'b1;
            end else begin
              res_d = '{vld: 1'b1, action: ACT_RELEASE, slot: slot_idx_i,
                        note: slot_q.pitch, chan: slot_q.owner};
              slot_d.free = 1'b1;
              slot_d.held = 1'b0;
            end
          end
        end
        OP_PEDAL: begin
          if (tok_i.rel && match && slot_q.held) begin
            res_d = '{vld: 1'b1, action: ACT_RELEASE, slot: slot_idx_i,
                      note: slot_q.pitch, chan: slot_q.owner};
            slot_d.free = 1'b1;
            slot_d.held = 1'b0;
          end
        end
        default: begin
          if (match) begin
            slot_d.stamp = tok_i.now;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      res_q  <= '0;
      slot_q <= '{free: 1'b1, held: 1'b0, owner: '0, pitch: '0, stamp: '0};
    end else if (adv_i) begin
      tok_q  <= tok_d;
      res_q  <= res_d;
      slot_q <= slot_d;
    end
  end

  assign tok_o = tok_q;
  assign res_o = res_q;

endmodule

[rtl/core/svalloc_ctrl.sv]
// event sequencer, pedal levels and result buffering of the allocator
`timescale 1ns / 1ps

module svalloc_ctrl import svalloc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_operation_i,
  input  logic [CHAN_W-1:0] in_midi_channel_i,
  input  logic [NOTE_W-1:0] in_note_i,
  input  logic [NOTE_W-1:0] in_pedal_i,
  input  logic [TIME_W-1:0] in_timestamp_i,
  input  logic [NOTE_W-1:0] thr_i,
  input  logic [CHAN_W-1:0] perc_i,
  output tok_t              inj_tok_o,
  input  tok_t              end_tok_i,
  input  res_t              res_i,
  output logic              adv_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        out_action_o,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic [NOTE_W-1:0] out_slot_note_o,
  output logic [CHAN_W-1:0] out_slot_channel_o,
  output logic              out_last_o
);

  state_e            state_q, state_d;
  logic [NOTE_W-1:0] pedal_q [NUM_CHANNELS];
  res_t              extra_q, extra_d;
  res_t              pend_q, pend_d;
  res_t              out_q, out_d;
  logic              last_q, last_d;
  logic              accept, out_free, pass_end, steal_go, no_claim;
  logic              new_vld, absorb, flush;
  res_t              new_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign adv_o      = !(res_i.vld && pend_q.vld && !out_free);

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_q.vld || !out_stall_i;
  assign pass_end = end_tok_i.vld && adv_o;
  assign no_claim = (end_tok_i.op == OP_NOTE_ON) && !end_tok_i.steal && !end_tok_i.claimed;
  assign steal_go = no_claim && end_tok_i.found && (end_tok_i.ch != perc_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SCAN;
      ST_SCAN: begin
        if (pass_end) begin
          if (steal_go) state_d = ST_STEAL;
          else if (no_claim) state_d = ST_EXTRA;
          else state_d = ST_FLUSH;
        end
      end
      ST_STEAL: if (pass_end) state_d = ST_EXTRA;
      ST_EXTRA: if (!pend_q.vld || out_free) state_d = ST_FLUSH;
      ST_FLUSH: if (!pend_q.vld || out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    inj_tok_o  = '0;
    new_vld    = 1'b0;
    new_res    = res_i;
    extra_d    = extra_q;
    unique case (state_q)
      ST_IDLE: begin
        inj_tok_o.vld       = accept;
        inj_tok_o.op        = op_e'(in_operation_i);
        inj_tok_o.ch        = in_midi_channel_i;
        inj_tok_o.nt        = in_note_i;
        inj_tok_o.now       = in_timestamp_i;
        inj_tok_o.hold      = (pedal_q[in_midi_channel_i] >= thr_i);
        inj_tok_o.rel       = (in_pedal_i < thr_i);
        inj_tok_o.best_time = in_timestamp_i;
      end
      ST_SCAN: begin
        new_vld = res_i.vld && adv_o;
        if (pass_end) begin
          if (steal_go) begin
            inj_tok_o       = end_tok_i;
            inj_tok_o.steal = 1'b1;
          end
          extra_d = '{vld: 1'b1, action: ACT_DROP, slot: '0,
                      note: end_tok_i.nt, chan: end_tok_i.ch};
        end
      end
      ST_STEAL: begin
        new_vld = res_i.vld && adv_o;
        if (pass_end) begin
          extra_d = '{vld: 1'b1, action: ACT_KEYON, slot: end_tok_i.best_idx,
                      note: end_tok_i.nt, chan: end_tok_i.ch};
        end
      end
      ST_EXTRA: begin
        new_vld = 1'b1;
        new_res = extra_q;
      end
      ST_FLUSH: ;
      default: ;
    endcase
  end

  // pending result and output register
  always_comb begin
    absorb = new_vld && (!pend_q.vld || out_free);
    flush  = (state_q == ST_FLUSH) && pend_q.vld && out_free;
    pend_d = pend_q;
    out_d  = out_q;
    last_d = last_q;
    if (out_q.vld && !out_stall_i) out_d.vld = 1'b0;
    if (absorb) begin
      if (pend_q.vld) begin
        out_d  = pend_q;
        last_d = 1'b0;
      end
      pend_d     = new_res;
      pend_d.vld = 1'b1;
    end
    if (flush) begin
      out_d      = pend_q;
      last_d     = 1'b1;
      pend_d.vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      extra_q <= '0;
      pend_q  <= '0;
      out_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      extra_q <= extra_d;
      pend_q  <= pend_d;
      out_q   <= out_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) pedal_q[c] <= '0;
    end else if (accept && (op_e'(in_operation_i) == OP_PEDAL)) begin
      pedal_q[in_midi_channel_i] <= in_pedal_i;
    end
  end

  assign out_valid_o        = out_q.vld;
  assign out_action_o       = out_q.action;
  assign out_slot_o         = out_q.slot;
  assign out_slot_note_o    = out_q.note;
  assign out_slot_channel_o = out_q.chan;
  assign out_last_o         = last_q;

endmodule

[rtl/core/synth_voice_allocator.sv]
// top level: config registers, slot cell chain and sequencer
// an event walks the cell chain, twice on a steal, before its last result reaches the output,
// and output stalls hold it back further
// a new event is taken only once the last result of the current one has left the pending
// register, so events never overlap in the cell chain
// reset: all slots free, pedal levels zero, threshold 64, percussion channel 9
`timescale 1ns / 1ps

module synth_voice_allocator import svalloc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_operation_i,
  input  logic [CHAN_W-1:0] in_midi_channel_i,
  input  logic [NOTE_W-1:0] in_note_i,
  input  logic [NOTE_W-1:0] in_pedal_i,
  input  logic [TIME_W-1:0] in_timestamp_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        out_action_o,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic [NOTE_W-1:0] out_slot_note_o,
  output logic [CHAN_W-1:0] out_slot_channel_o,
  output logic              out_last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [NOTE_W-1:0] thr_q;
  logic [CHAN_W-1:0] perc_q;
  logic              cfg_wr, adv;
  tok_t              tok_w [NUM_SLOTS+1];
  res_t              res_w [NUM_SLOTS];
  res_t              res_any;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      perc_q <= PERC_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SUSTAIN:    thr_q  <= pwdata[NOTE_W-1:0];
        REG_PERCUSSION: perc_q <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SUSTAIN:    prdata = {{(DATA_W-NOTE_W){1'b0}}, thr_q};
      REG_PERCUSSION: prdata = {{(DATA_W-CHAN_W){1'b0}}, perc_q};
      default:        prdata = '0;
    endcase
  end

  svalloc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_operation_i,
    .in_midi_channel_i,
    .in_note_i,
    .in_pedal_i,
    .in_timestamp_i,
    .thr_i      (thr_q),
    .perc_i     (perc_q),
    .inj_tok_o  (tok_w[0]),
    .end_tok_i  (tok_w[NUM_SLOTS]),
    .res_i      (res_any),
    .adv_o      (adv),
    .out_valid_o,
    .out_stall_i,
    .out_action_o,
    .out_slot_o,
    .out_slot_note_o,
    .out_slot_channel_o,
    .out_last_o
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    svalloc_cell u_cell (
      .clk_i,
      .rst_ni,
      .adv_i      (adv),
      .slot_idx_i (SLOT_W'(i)),
      .tok_i      (tok_w[i]),
      .tok_o      (tok_w[i+1]),
      .res_o      (res_w[i])
    );
  end

  // at most one cell reports per cycle
  always_comb begin
    res_any = '0;
    for (int i = 0; i < NUM_SLOTS; i++) res_any = res_t'(res_any | res_w[i]);
  end

endmodule

[rtl/core/svalloc_checker.sv]
// port level checks of the voice slot allocator and their binding
`timescale 1ns / 1ps

module svalloc_checker import svalloc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        out_action_o,
  input logic [SLOT_W-1:0] out_slot_o,
  input logic [NOTE_W-1:0] out_slot_note_o,
  input logic [CHAN_W-1:0] out_slot_channel_o,
  input logic              out_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_action_o) && $stable(out_slot_o)
      && $stable(out_slot_note_o) && $stable(out_slot_channel_o) && $stable(out_last_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second event taken while busy");

  a_drop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_action_o == ACT_DROP) |-> (out_slot_o == '0) && out_last_o)
    else $error("dropped note not a lone result in slot zero");

  a_steal_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_action_o == ACT_STEAL) |-> !out_last_o)
    else $error("stolen slot without key on");

endmodule

bind synth_voice_allocator svalloc_checker u_svalloc_checker (.*);

[verif/synth_voice_allocator_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of synth_voice_allocator: event traffic, slot predictor, result checks
module synth_voice_allocator_test;
  import svalloc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 2 * NUM_SLOTS + 12;

  typedef struct packed {
    act_e              action;
    logic [SLOT_W-1:0] slot;
    logic [NOTE_W-1:0] note;
    logic [CHAN_W-1:0] chan;
    logic              last;
  } voice_action_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_operation;
  logic [CHAN_W-1:0] in_midi_channel;
  logic [NOTE_W-1:0] in_note;
  logic [NOTE_W-1:0] in_pedal;
  logic [TIME_W-1:0] in_timestamp;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_action;
  logic [SLOT_W-1:0] out_slot;
  logic [NOTE_W-1:0] out_slot_note;
  logic [CHAN_W-1:0] out_slot_channel;
  logic              out_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor state
  logic              slot_free  [NUM_SLOTS];
  logic [CHAN_W-1:0] slot_owner [NUM_SLOTS];
  logic [NOTE_W-1:0] slot_pitch [NUM_SLOTS];
  logic              slot_held  [NUM_SLOTS];
  logic [TIME_W-1:0] slot_stamp [NUM_SLOTS];
  logic [NOTE_W-1:0] chan_pedal [NUM_CHANNELS];
  logic [NOTE_W-1:0] sustain_thr;
  logic [CHAN_W-1:0] perc_chan;

  voice_action_t pending_actions[$];
  voice_action_t head;

  logic [TIME_W-1:0] clock_ms;
  int tx_idle_pct;
  int rx_idle_pct;
  int error_count;
  int idle_cycles;
  int events_sent;
  int results_seen;
  int steals_seen;
  int drops_seen;
  int releases_seen;

  synth_voice_allocator DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_operation_i     (in_operation),
    .in_midi_channel_i  (in_midi_channel),
    .in_note_i          (in_note),
    .in_pedal_i         (in_pedal),
    .in_timestamp_i     (in_timestamp),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_action_o       (out_action),
    .out_slot_o         (out_slot),
    .out_slot_note_o    (out_slot_note),
    .out_slot_channel_o (out_slot_channel),
    .out_last_o         (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    if (error_count < 10) $display("mismatch: %s", msg);
    error_count++;
  endfunction

  function automatic voice_action_t voice_action(act_e act, int s, logic [NOTE_W-1:0] nt,
                                                 logic [CHAN_W-1:0] ch);
    voice_action_t a;
    a.action = act;
    a.slot   = SLOT_W'(s);
    a.note   = nt;
    a.chan   = ch;
    a.last   = 1'b0;
    return a;
  endfunction

  function automatic void key_on_slot(int s, logic [CHAN_W-1:0] ch, logic [NOTE_W-1:0] nt,
                                      logic [TIME_W-1:0] now);
    slot_free[s]  = 1'b0;
    slot_held[s]  = 1'b0;
    slot_owner[s] = ch;
    slot_pitch[s] = nt;
    slot_stamp[s] = now;
  endfunction

  // expected voice actions of one accepted event, state updated in place
  function automatic void apply_event(op_e op, logic [CHAN_W-1:0] ch, logic [NOTE_W-1:0] nt,
                                      logic [NOTE_W-1:0] pd, logic [TIME_W-1:0] now);
    voice_action_t acts[$];
    int pick;
    int oldest;
    logic [TIME_W-1:0] oldest_time;
    logic hold;
    pick = -1;
    case (op)
      OP_NOTE_ON: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_free[i] && pick < 0) pick = i;
        if (pick >= 0) begin
          key_on_slot(pick, ch, nt, now);
          acts.push_back(voice_action(ACT_KEYON, pick, nt, ch));
        end else begin
          oldest = -1;
          oldest_time = now;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_stamp[i] < oldest_time) begin
              oldest_time = slot_stamp[i];
              oldest = i;
            end
          end
          if (ch != perc_chan && oldest >= 0) begin
            acts.push_back(voice_action(ACT_STEAL, oldest, slot_pitch[oldest],
                                        slot_owner[oldest]));
            key_on_slot(oldest, ch, nt, now);
            acts.push_back(voice_action(ACT_KEYON, oldest, nt, ch));
          end else begin
            acts.push_back(voice_action(ACT_DROP, 0, nt, ch));
          end
        end
      end
      OP_NOTE_OFF: begin
        hold = chan_pedal[ch] >= sustain_thr;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_free[i] && slot_owner[i] == ch && slot_pitch[i] == nt) begin
            if (hold) begin
              slot_held[i] = 1'b1;
            end else begin
              acts.push_back(voice_action(ACT_RELEASE, i, slot_pitch[i], slot_owner[i]));
              slot_free[i] = 1'b1;
              slot_held[i] = 1'b0;
            end
          end
        end
      end
      OP_PEDAL: begin
        chan_pedal[ch] = pd;
        if (pd < sustain_thr) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_free[i] && slot_owner[i] == ch && slot_held[i]) begin
              acts.push_back(voice_action(ACT_RELEASE, i, slot_pitch[i], slot_owner[i]));
              slot_free[i] = 1'b1;
              slot_held[i] = 1'b0;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!slot_free[i] && slot_owner[i] == ch) slot_stamp[i] = now;
      end
    endcase
    if (acts.size() > 0) acts[acts.size() - 1].last = 1'b1;
    foreach (acts[i]) pending_actions.push_back(acts[i]);
  endfunction

  task automatic send_event(op_e op, logic [CHAN_W-1:0] ch, logic [NOTE_W-1:0] nt,
                            logic [NOTE_W-1:0] pd, logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_operation    = op;
    in_midi_channel = ch;
    in_note         = nt;
    in_pedal        = pd;
    in_timestamp    = now;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    apply_event(op, ch, nt, pd, now);
    events_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write then read back one register
  task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] want;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx == REG_SUSTAIN) sustain_thr = value[NOTE_W-1:0];
    else perc_chan = value[CHAN_W-1:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    want = (idx == REG_SUSTAIN) ? DATA_W'(sustain_thr) : DATA_W'(perc_chan);
    if (prdata !== want)
      flag_error($sformatf("register %0d read 0x%0h, expected 0x%0h", idx, prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic random_events(int count);
    op_e op;
    logic [CHAN_W-1:0] ch;
    logic [NOTE_W-1:0] nt;
    logic [NOTE_W-1:0] pd;
    int roll;
    int s;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 40) op = OP_NOTE_ON;
      else if (roll < 70) op = OP_NOTE_OFF;
      else if (roll < 85) op = OP_PEDAL;
      else op = OP_TOUCH;
      case ($urandom_range(7))
        0: ch = perc_chan;
        1: ch = CHAN_W'($urandom);
        default: ch = CHAN_W'($urandom_range(3));
      endcase
      if ($urandom_range(9) < 7) nt = NOTE_W'(60 + $urandom_range(3));
      else nt = NOTE_W'($urandom);
      // note off mostly aimed at a sounding voice
      if (op == OP_NOTE_OFF && $urandom_range(9) < 7) begin
        s = $urandom_range(NUM_SLOTS - 1);
        if (!slot_free[s]) begin
          ch = slot_owner[s];
          nt = slot_pitch[s];
        end
      end
      case ($urandom_range(4))
        0: pd = '0;
        1: pd = '1;
        2: pd = sustain_thr;
        3: pd = sustain_thr - 1'b1;
        default: pd = NOTE_W'($urandom);
      endcase
      case ($urandom_range(19))
        0: clock_ms = $urandom;
        1: clock_ms = clock_ms - TIME_W'($urandom_range(200));
        default: clock_ms = clock_ms + TIME_W'($urandom_range(40));
      endcase
      send_event(op, ch, nt, pd, clock_ms);
    end
  endtask

  task automatic test_directed_cases();
    tx_idle_pct = 7;
    rx_idle_pct = 65;
    for (int i = 0; i < NUM_SLOTS; i++)
      send_event(OP_NOTE_ON, CHAN_W'(i), (i == NUM_SLOTS - 1) ? 7'd127 : NOTE_W'(i * 15),
                 7'd0, TIME_W'(i * 10));
    // all slots busy, nothing older than now
    send_event(OP_NOTE_ON, 4'd1, 7'd50, 7'd0, 32'd0);
    // percussion channel with no free slot
    send_event(OP_NOTE_ON, PERC_RESET, 7'd36, 7'd0, 32'd5000);
    // steal of the oldest voice
    send_event(OP_NOTE_ON, 4'd15, 7'd60, 7'd0, 32'd5000);
    // sustain: hold on note off, release on pedal drop below threshold
    send_event(OP_PEDAL, 4'd2, 7'd0, 7'd127, 32'd5001);
    send_event(OP_NOTE_OFF, 4'd2, 7'd30, 7'd0, 32'd5002);
    send_event(OP_PEDAL, 4'd2, 7'd0, THR_RESET, 32'd5003);
    send_event(OP_PEDAL, 4'd2, 7'd0, THR_RESET - 1'b1, 32'd5004);
    // free slot never matched
    send_event(OP_NOTE_OFF, 4'd2, 7'd30, 7'd0, 32'd5005);
    send_event(OP_TOUCH, 4'd15, 7'd0, 7'd0, 32'hFFFF_FFFF);
    send_event(OP_NOTE_ON, 4'd4, 7'd60, 7'd0, 32'd100);
    send_event(OP_NOTE_ON, 4'd0, 7'd1, 7'd0, 32'h8000_0000);
    send_event(OP_NOTE_OFF, 4'd4, 7'd60, 7'd0, 32'd6000);
    send_event(OP_PEDAL, 4'd7, 7'd0, 7'd0, 32'd6001);
    // two voices on the same note released together
    send_event(OP_NOTE_ON, 4'd15, 7'd60, 7'd0, 32'd6002);
    send_event(OP_NOTE_OFF, 4'd15, 7'd60, 7'd0, 32'd6003);
    wait_idle();
  endtask

  task automatic test_hold_everything();
    tx_idle_pct = 7;
    rx_idle_pct = 65;
    write_reg(REG_SUSTAIN, 32'd0);
    write_reg(REG_PERCUSSION, 32'd0);
    random_events(100);
    wait_idle();
  endtask

  task automatic test_pedal_releases();
    tx_idle_pct = 65;
    rx_idle_pct = 7;
    write_reg(REG_SUSTAIN, 32'd127);
    write_reg(REG_PERCUSSION, 32'd15);
    random_events(100);
    wait_idle();
  endtask

  task automatic test_random_registers();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_SUSTAIN, DATA_W'($urandom_range(127)));
    write_reg(REG_PERCUSSION, DATA_W'($urandom_range(15)));
    random_events(90);
    wait_idle();
  endtask

  always @(negedge clk) out_stall = rst_n && ($urandom_range(99) < rx_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_actions.size() == 0) begin
        flag_error($sformatf("unexpected result action %0d slot %0d note %0d chan %0d",
                             out_action, out_slot, out_slot_note, out_slot_channel));
      end else begin
        head = pending_actions.pop_front();
        case (head.action)
          ACT_STEAL:   steals_seen++;
          ACT_DROP:    drops_seen++;
          ACT_RELEASE: releases_seen++;
          default: ;
        endcase
        if (out_action !== head.action || out_slot !== head.slot ||
            out_slot_note !== head.note || out_slot_channel !== head.chan ||
            out_last !== head.last)
          flag_error($sformatf(
            "expected act %0d slot %0d note %0d chan %0d last %0d, got %0d %0d %0d %0d %0d",
            head.action, head.slot, head.note, head.chan, head.last,
            out_action, out_slot, out_slot_note, out_slot_channel, out_last));
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_valid        = 1'b0;
    in_operation    = OP_NOTE_ON;
    in_midi_channel = '0;
    in_note         = '0;
    in_pedal        = '0;
    in_timestamp    = '0;
    out_stall       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    error_count     = 0;
    idle_cycles     = 0;
    events_sent     = 0;
    results_seen    = 0;
    steals_seen     = 0;
    drops_seen      = 0;
    releases_seen   = 0;
    clock_ms        = 32'd7000;
    sustain_thr     = THR_RESET;
    perc_chan       = PERC_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_free[i]  = 1'b1;
      slot_owner[i] = '0;
      slot_pitch[i] = '0;
      slot_held[i]  = 1'b0;
      slot_stamp[i] = '0;
    end
    for (int i = 0; i < NUM_CHANNELS; i++) chan_pedal[i] = '0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_hold_everything();
    test_pedal_releases();
    test_random_registers();

    $display("run covered %0d events and %0d results over four register settings",
             events_sent, results_seen);
    $display("  %0d steals, %0d drops, %0d releases, %0d mismatches",
             steals_seen, drops_seen, releases_seen, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[synth_voice_allocator.f]
rtl/core/svalloc_pkg.sv
rtl/core/svalloc_cell.sv
rtl/core/svalloc_ctrl.sv
rtl/core/synth_voice_allocator.sv
rtl/core/svalloc_checker.sv
verif/synth_voice_allocator_test.sv
